// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CHECK(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== hw/rtl/sil_pkg.sv =====
package sil_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LIST   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_LISTED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [VAL_W-1:0]  value;
  } req_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    req_t  req;
  } head_t;

  typedef struct packed {
    logic              strobe;
    status_t           status;
    logic [VAL_W-1:0]  value;
    logic              last;
  } res_t;

endpackage

// ===== hw/rtl/sorted_insert_list_core.sv =====
// Sorted list of up to 16 signed 16-bit values, ascending; a new value goes
// ahead of equal ones already stored. A request is taken when start is high
// and busy is low. Mode 0 inserts new_value and answers with one strobed
// result (status inserted, or full and dropped) from the back end; inserts
// are taken one per cycle back to back while busy is low. Mode 1 lists the
// stored values, one strobed result per cycle with last on the final one;
// it holds the back end until the last value is shown, and an empty list
// answers with a single empty result. A two-entry request queue sits in
// front of the back end, and busy is high only while it is full. Results
// are shown for one cycle only and cannot be held off.
`include "assert_macros.svh"

module sorted_insert_list_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        mode,
  input  logic signed [15:0]          new_value,
  output logic                        busy,
  output logic                        strobe,
  output logic [1:0]                  status,
  output logic signed [15:0]          out_value,
  output logic                        last
);

  sil_pkg::head_t head;
  sil_pkg::res_t  res;
  logic           pop;
  logic [1:0]     level;

  sil_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .new_value (new_value),
    .pop       (pop),
    .busy      (busy),
    .head      (head),
    .level     (level)
  );

  sil_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

  assign strobe    = res.strobe;
  assign status    = res.status;
  assign out_value = $signed(res.value);
  assign last      = res.last;

  `ASSERT_NEVER(a_level_range, clk, rst, level == 2'd3, "queue level out of range")
  `ASSERT_CHECK(a_busy_full, clk, rst, busy == (level == 2'd2), "busy does not track queue fill")
  `ASSERT_CHECK(a_list_run, clk, rst, (strobe && status == sil_pkg::ST_LISTED && !last) |=> (strobe && status == sil_pkg::ST_LISTED), "listing interrupted")
  `ASSERT_CHECK(a_single_ack, clk, rst, (strobe && status != sil_pkg::ST_LISTED) |-> last, "acknowledgement without last")

endmodule

// ===== hw/rtl/sil_front.sv =====
module sil_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        mode,
  input  logic [sil_pkg::VAL_W-1:0]   new_value,
  input  logic                        pop,
  output logic                        busy,
  output sil_pkg::head_t              head,
  output logic [1:0]                  level
);

  sil_pkg::req_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          do_pop;
  sil_pkg::req_t req_in;

  assign busy   = (fill == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (fill != 2'd0);
  assign level  = fill;

  always_comb begin
    req_in.op    = mode ? sil_pkg::OP_LIST : sil_pkg::OP_INSERT;
    req_in.value = new_value;
  end

  assign head.valid = (fill != 2'd0);
  assign head.req   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sil_back.sv =====
module sil_back (
  input  logic            clk,
  input  logic            rst,
  input  sil_pkg::head_t  head,
  output logic            pop,
  output sil_pkg::res_t   res
);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t                            state;
  logic [sil_pkg::CNT_W-1:0]         count;
  logic [sil_pkg::IDX_W-1:0]         idx;
  logic signed [sil_pkg::VAL_W-1:0]  cells [sil_pkg::DEPTH];
  logic signed [sil_pkg::VAL_W-1:0]  cells_next [sil_pkg::DEPTH];
  logic [sil_pkg::DEPTH-1:0]         lt;
  logic signed [sil_pkg::VAL_W-1:0]  x;
  logic                              full;
  logic                              do_insert;
  logic                              list_last;

  assign x         = $signed(head.req.value);
  assign full      = (count == sil_pkg::CNT_W'(sil_pkg::DEPTH));
  assign pop       = head.valid && (state == S_IDLE);
  assign do_insert = pop && (head.req.op == sil_pkg::OP_INSERT) && !full;
  assign list_last = ((sil_pkg::CNT_W'(idx) + sil_pkg::CNT_W'(1)) == count);

  // each cell compares against the new value; the row is sorted, so the
  // first cell that is not below x is the insertion point
  always_comb begin
    for (int i = 0; i < sil_pkg::DEPTH; i++) begin
      lt[i] = (sil_pkg::CNT_W'(i) < count) && (cells[i] < x);
    end
    cells_next[0] = lt[0] ? cells[0] : x;
    for (int i = 1; i < sil_pkg::DEPTH; i++) begin
      if (lt[i]) begin
        cells_next[i] = cells[i];
      end else if (lt[i-1]) begin
        cells_next[i] = x;
      end else begin
        cells_next[i] = cells[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < sil_pkg::DEPTH; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      idx        <= '0;
      res.strobe <= 1'b0;
      res.status <= sil_pkg::ST_INSERTED;
      res.value  <= '0;
      res.last   <= 1'b0;
    end else begin
      res.strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (head.req.op)
              sil_pkg::OP_INSERT: begin
                res.strobe <= 1'b1;
                res.value  <= head.req.value;
                res.last   <= 1'b1;
                if (full) begin
                  res.status <= sil_pkg::ST_FULL;
                end else begin
                  res.status <= sil_pkg::ST_INSERTED;
                  count      <= count + sil_pkg::CNT_W'(1);
                end
              end
              sil_pkg::OP_LIST: begin
                if (count == '0) begin
                  res.strobe <= 1'b1;
                  res.status <= sil_pkg::ST_EMPTY;
                  res.value  <= '0;
                  res.last   <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= S_LIST;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LIST: begin
          res.strobe <= 1'b1;
          res.status <= sil_pkg::ST_LISTED;
          res.value  <= cells[idx];
          res.last   <= list_last;
          idx        <= idx + sil_pkg::IDX_W'(1);
          if (list_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/sorted_insert_list_core_tb.sv =====
`timescale 1ns / 100ps

module sorted_insert_list_core_tb;
  import sil_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_REQS = 450;
  localparam int MAX_REPORTS = 50;

  typedef struct {
    status_t            st;
    logic signed [15:0] val;
    logic               lst;
  } result_t;

  typedef struct {
    op_t                op;
    logic signed [15:0] val;
    logic               chk;
    status_t            st;
  } row_t;

  // directed requests; chk rows carry a hand-written first result
  row_t plan [22] = '{
    row_t'{OP_LIST,   16'sh0000, 1'b1, ST_EMPTY},
    row_t'{OP_INSERT, 16'sh0000, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh7fff, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh8000, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh0000, 1'b1, ST_INSERTED},
    row_t'{OP_LIST,   16'sh1234, 1'b0, ST_LISTED},
    row_t'{OP_INSERT, 16'shffff, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh0001, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh8001, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh7ffe, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh0005, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh0005, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'shff9c, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh0064, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh5555, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'shaaaa, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh0000, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh7fff, 1'b1, ST_INSERTED},
    row_t'{OP_INSERT, 16'sh1234, 1'b1, ST_FULL},
    row_t'{OP_LIST,   16'sh0000, 1'b0, ST_LISTED},
    row_t'{OP_INSERT, 16'sh8000, 1'b1, ST_FULL},
    row_t'{OP_LIST,   16'shffff, 1'b0, ST_LISTED}
  };

  logic               clk;
  logic               rst;
  logic               start;
  logic               mode;
  logic signed [15:0] new_value;
  logic               busy;
  logic               strobe;
  logic [1:0]         status;
  logic signed [15:0] out_value;
  logic               last;

  logic               row_chk;
  status_t            row_st;

  logic signed [15:0] sorted_vals [DEPTH];
  int                 held_cnt;
  result_t            pending_results [$];
  int                 errors;
  int                 idle_cycles;
  int                 no_gap_left;

  sorted_insert_list_core u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .new_value (new_value),
    .busy      (busy),
    .strobe    (strobe),
    .status    (status),
    .out_value (out_value),
    .last      (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // updates the shadow list and queues every result the request causes
  task automatic predict_request(input op_t op, input logic signed [15:0] v,
                                 output result_t first);
    int      pos;
    int      i;
    result_t r;
    if (op == OP_INSERT) begin
      if (held_cnt >= DEPTH) begin
        r = '{ST_FULL, v, 1'b1};
      end else begin
        pos = 0;
        while (pos < held_cnt && sorted_vals[pos] < v) pos++;
        for (i = held_cnt; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[pos] = v;
        held_cnt++;
        r = '{ST_INSERTED, v, 1'b1};
      end
      pending_results.push_back(r);
      first = r;
    end else if (held_cnt == 0) begin
      r = '{ST_EMPTY, 16'sd0, 1'b1};
      pending_results.push_back(r);
      first = r;
    end else begin
      for (i = 0; i < held_cnt; i++) begin
        r = '{ST_LISTED, sorted_vals[i], (i + 1 == held_cnt)};
        pending_results.push_back(r);
        if (i == 0) first = r;
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t first;
    logic    took;
    took = 1'b0;
    if (!rst) begin
      // results first: anything strobed now belongs to an older request
      if (strobe === 1'b1) begin
        took = 1'b1;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result status=%0d value=%0d last=%0b",
                     $time, status, out_value, last);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st || out_value !== want.val || last !== want.lst) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: mismatch expected st=%0d val=%0d last=%0b, %s",
                       $time, want.st, want.val, want.lst,
                       $sformatf("got st=%0d val=%0d last=%0b",
                                 status, out_value, last));
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        took = 1'b1;
        predict_request(op_t'(mode), new_value, first);
        if (row_chk && (first.st !== row_st ||
            first.val !== ((row_st == ST_EMPTY) ? 16'sd0 : new_value))) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: directed mismatch expected st=%0d val=%0d, got st=%0d val=%0d",
                     $time, row_st, (row_st == ST_EMPTY) ? 16'sd0 : new_value,
                     first.st, first.val);
        end
      end
    end
    idle_cycles = took ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("sorted_insert_list_core_tb: errors");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input op_t op, input logic signed [15:0] v,
                              input logic chk, input status_t st);
    int gap;
    gap = (no_gap_left > 0) ? 0 : $urandom_range(0, 8);
    if (no_gap_left > 0) no_gap_left--;
    if (gap > 0) begin
      start = 1'b0;
      new_value = 16'($urandom);
      mode = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    mode = op;
    new_value = v;
    row_chk = chk;
    row_st = st;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    @(negedge clk);
  endtask

  initial begin
    op_t                op;
    logic signed [15:0] v;
    int                 n;
    rst = 1'b1;
    start = 1'b0;
    mode = OP_INSERT;
    new_value = '0;
    row_chk = 1'b0;
    row_st = ST_INSERTED;
    held_cnt = 0;
    errors = 0;
    idle_cycles = 0;
    no_gap_left = 0;
    foreach (sorted_vals[k]) sorted_vals[k] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[k]) send_request(plan[k].op, plan[k].val, plan[k].chk, plan[k].st);

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (no_gap_left == 0 && $urandom_range(0, 15) == 0)
        no_gap_left = $urandom_range(5, 20);
      op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_LIST;
      case ($urandom_range(0, 7))
        0: v = 16'sh8000;
        1: v = 16'sh7fff;
        default: v = 16'($urandom);
      endcase
      send_request(op, v, 1'b0, ST_INSERTED);
    end
    start = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("sorted_insert_list_core_tb: clean");
    else
      $display("sorted_insert_list_core_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sil_pkg.sv
hw/rtl/sil_front.sv
hw/rtl/sil_back.sv
hw/rtl/sorted_insert_list_core.sv
dv/sorted_insert_list_core_tb.sv
